### design/stt_pkg.sv
// Shared types, codes and helpers for the scene text tokenizer.
package stt_pkg;

  typedef enum logic [3:0] {
    KIND_TAG          = 4'd0,
    KIND_NAME         = 4'd1,
    KIND_STRING       = 4'd2,
    KIND_NUMBER       = 4'd3,
    KIND_TUPLE        = 4'd4,
    KIND_END          = 4'd5,
    KIND_UNTERM_TAG   = 4'd6,
    KIND_UNTERM_NAME  = 4'd7,
    KIND_UNTERM_TUPLE = 4'd8
  } kind_e;

  localparam logic [7:0] ChrOpenTag   = 8'h5B;  // [
  localparam logic [7:0] ChrCloseTag  = 8'h5D;  // ]
  localparam logic [7:0] ChrColon     = 8'h3A;  // :
  localparam logic [7:0] ChrQuote     = 8'h22;  // "
  localparam logic [7:0] ChrOpenTup   = 8'h28;  // (
  localparam logic [7:0] ChrCloseTup  = 8'h29;  // )
  localparam logic [7:0] ChrNewline   = 8'h0A;

  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

  // One queue entry: everything a single input item produces.
  typedef struct packed {
    logic        has_tok;
    kind_e       tok_kind;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic        has_end;
    logic [15:0] end_start;
  } rec_t;

  function automatic logic [15:0] sat16(input logic [32:0] v);
    sat16 = (v > 33'h0FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

### design/stt_if.sv
// Valid/ready channel interfaces for input bytes and output tokens.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_buffer;

  modport source (output valid, output byte_value, output end_of_buffer, input ready);
  modport sink   (input valid, input byte_value, input end_of_buffer, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] start_position;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_position,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_position,
                  input token_length, input last_of_run, output ready);
endinterface

### design/stt_scanner.sv
// Front end: token scanner state machine, builds one record per closing or end item.
module stt_scanner #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    byte_i,
  input  logic          eob_i,
  output logic          push_o,
  output stt_pkg::rec_t rec_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_TAG    = 6'b000010,
    ST_NAME   = 6'b000100,
    ST_STRING = 6'b001000,
    ST_NUMBER = 6'b010000,
    ST_TUPLE  = 6'b100000
  } mode_e;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS:0]   held;
  logic                     is_space, is_letter, is_digit;
  logic                     close;

  assign held      = {1'b0, pos_q} - {1'b0, start_q};
  assign is_space  = (byte_i == 8'h20) || (byte_i >= 8'h09 && byte_i <= 8'h0D);
  assign is_letter = (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
                     (byte_i >= 8'h61 && byte_i <= 8'h7A);
  assign is_digit  = (byte_i >= 8'h30 && byte_i <= 8'h39);

  always_comb begin
    mode_d          = mode_q;
    start_d         = start_q;
    pos_d           = pos_q;
    close           = 1'b0;
    rec_o           = '0;
    rec_o.tok_kind  = stt_pkg::KIND_TAG;
    rec_o.tok_start = stt_pkg::sat16(33'(start_q));
    rec_o.tok_len   = stt_pkg::sat16(33'(held));
    rec_o.end_start = stt_pkg::sat16(33'(pos_q));

    if (eob_i) begin
      rec_o.has_end = 1'b1;
      rec_o.has_tok = (mode_q != ST_IDLE);
      case (mode_q)
        ST_TAG:    rec_o.tok_kind = stt_pkg::KIND_UNTERM_TAG;
        ST_NAME:   rec_o.tok_kind = stt_pkg::KIND_UNTERM_NAME;
        ST_STRING: rec_o.tok_kind = stt_pkg::KIND_STRING;
        ST_NUMBER: rec_o.tok_kind = stt_pkg::KIND_NUMBER;
        ST_TUPLE:  rec_o.tok_kind = stt_pkg::KIND_UNTERM_TUPLE;
        default:   rec_o.tok_kind = stt_pkg::KIND_TAG;
      endcase
      mode_d  = ST_IDLE;
      start_d = '0;
      pos_d   = '0;
    end else begin
      case (mode_q)
        ST_IDLE: begin
          start_d = pos_q;
          if (is_space) begin
            start_d = start_q;
          end else if (byte_i == stt_pkg::ChrOpenTag) begin
            mode_d = ST_TAG;
          end else if (is_letter) begin
            mode_d = ST_NAME;
          end else if (byte_i == stt_pkg::ChrQuote) begin
            mode_d = ST_STRING;
          end else if (is_digit) begin
            mode_d = ST_NUMBER;
          end else if (byte_i == stt_pkg::ChrOpenTup) begin
            mode_d = ST_TUPLE;
          end else begin
            start_d = start_q;  // stray byte, skipped
          end
        end
        ST_TAG: begin
          if (byte_i == stt_pkg::ChrCloseTag) begin
            close          = 1'b1;
            rec_o.tok_kind = stt_pkg::KIND_TAG;
            rec_o.tok_len  = stt_pkg::sat16(33'(held) + 33'd1);
          end
        end
        ST_NAME: begin
          if (byte_i == stt_pkg::ChrColon) begin
            close          = 1'b1;
            rec_o.tok_kind = stt_pkg::KIND_NAME;
          end
        end
        ST_STRING: begin
          if (byte_i == stt_pkg::ChrNewline) begin
            close          = 1'b1;
            rec_o.tok_kind = stt_pkg::KIND_STRING;
          end
        end
        ST_NUMBER: begin
          if (byte_i == stt_pkg::ChrNewline) begin
            close          = 1'b1;
            rec_o.tok_kind = stt_pkg::KIND_NUMBER;
          end
        end
        ST_TUPLE: begin
          if (byte_i == stt_pkg::ChrCloseTup) begin
            close          = 1'b1;
            rec_o.tok_kind = stt_pkg::KIND_TUPLE;
            rec_o.tok_len  = stt_pkg::sat16(33'(held) + 33'd1);
          end
        end
        default: mode_d = ST_IDLE;
      endcase
      if (close) begin
        rec_o.has_tok = 1'b1;
        mode_d        = ST_IDLE;
      end
      if (pos_q != PosMax) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  assign push_o = accept_i && (eob_i || close);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ST_IDLE;
      start_q <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
    end
  end

endmodule

### design/stt_queue.sv
// Short record queue between the scanner and the emitter.
module stt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  stt_pkg::rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output stt_pkg::rec_t head_o
);

  stt_pkg::rec_t                  mem_q [stt_pkg::QueueDepth];
  logic [stt_pkg::QueuePtrW-1:0]  wr_q, rd_q;
  logic [stt_pkg::QueuePtrW:0]    cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == (stt_pkg::QueuePtrW+1)'(stt_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### design/stt_emitter.sv
// Back end: unpacks each queued record into one or two output tokens.
module stt_emitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  stt_pkg::rec_t     head_i,
  output logic              pop_o,
  stt_out_if.source         out_o
);

  logic phase_q;    // token half of the head record already sent
  logic send_tok;
  logic last;
  logic fire;

  assign send_tok = head_i.has_tok && !phase_q;
  assign last     = !(send_tok && head_i.has_end);

  assign out_o.valid          = !empty_i;
  assign out_o.token_kind     = send_tok ? head_i.tok_kind : stt_pkg::KIND_END;
  assign out_o.start_position = send_tok ? head_i.tok_start : head_i.end_start;
  assign out_o.token_length   = send_tok ? head_i.tok_len : 16'd0;
  assign out_o.last_of_run    = last;

  assign fire  = out_o.valid && out_o.ready;
  assign pop_o = fire && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (fire) begin
      phase_q <= !last;
    end
  end

endmodule

### design/scene_text_tokenizer.sv
// Scene text tokenizer: byte stream in, classified tokens out.
// Throughput: one byte item per cycle while the queue has room; an end item yields up to
// two tokens, one per cycle while the receiver is ready.
// A four-entry record queue separates the scanner from the token emitter.
// Reset (rst_ni low, async): scanner idle, position and start zero, queue empty.
module scene_text_tokenizer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stt_in_if.sink     in_i,
  stt_out_if.source  out_o
);

  logic          accept;
  logic          push;
  logic          full;
  logic          empty;
  logic          pop;
  stt_pkg::rec_t rec;
  stt_pkg::rec_t head;

  // Input is taken whenever the queue has room, independent of the output side.
  assign in_i.ready = !full;
  assign accept     = in_i.valid && in_i.ready;

  // Front: mode tracking, position counting, token closing.
  stt_scanner #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scanner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (in_i.byte_value),
    .eob_i   (in_i.end_of_buffer),
    .push_o  (push),
    .rec_o   (rec)
  );

  // Records of items that close a token or end the buffer.
  stt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head)
  );

  // Back: token output, end item split into its two tokens.
  stt_emitter u_emitter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

### test/tb_top.sv
// Self-checking testbench for the scene text tokenizer.
`timescale 1ns / 1ps

module tb_top;

  // Scanner state of the predictor.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_TAG,
    SCAN_NAME,
    SCAN_STRING,
    SCAN_NUMBER,
    SCAN_TUPLE
  } scan_mode_e;

  // One output token as the receiver sees it.
  typedef struct packed {
    stt_pkg::kind_e kind;
    logic [15:0]    start;
    logic [15:0]    len;
    logic           last;
  } token_t;

  // Directed stimulus row. fixed < 0: the predictor supplies the tokens;
  // otherwise fixed is the number of tokens typed in (k0/s0/l0, k1/s1/l1).
  typedef struct {
    logic [7:0]     b;
    logic           eob;
    int             fixed;
    stt_pkg::kind_e k0;
    int             s0;
    int             l0;
    stt_pkg::kind_e k1;
    int             s1;
    int             l1;
  } row_t;

  localparam int DirectedRows = 26;
  localparam int RandomItems  = 475;
  localparam int HoldCycles   = 60;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  stt_in_if  in_if ();
  stt_out_if out_if ();

  scene_text_tokenizer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit: the slowest legal run is well under a tenth of this.
  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Token predictor
  // --------------------------------------------------------------------------
  scan_mode_e  scan_mode  = SCAN_IDLE;
  logic [15:0] scan_start = '0;
  logic [15:0] scan_pos   = '0;  // offset of the next byte, sticks at all-ones
  token_t      step_tokens[$];   // tokens caused by the last accepted item
  token_t      expected_tokens[$];

  function automatic token_t make_token(input stt_pkg::kind_e k, input logic [15:0] s,
                                        input logic [16:0] l);
    token_t t;
    t.kind  = k;
    t.start = s;
    t.len   = (l > 17'h0FFFF) ? 16'hFFFF : l[15:0];
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic void open_scan(input scan_mode_e m);
    scan_mode  = m;
    scan_start = scan_pos;
  endfunction

  function automatic void tokenize_item(input logic [7:0] b, input logic eob);
    logic [16:0] held;
    token_t      tail;
    held = {1'b0, scan_pos - scan_start};
    step_tokens.delete();
    if (eob) begin
      // Flush whatever is open, then the end token; back to the reset state.
      case (scan_mode)
        SCAN_TAG:
          step_tokens.push_back(make_token(stt_pkg::KIND_UNTERM_TAG, scan_start, held));
        SCAN_NAME:
          step_tokens.push_back(make_token(stt_pkg::KIND_UNTERM_NAME, scan_start, held));
        SCAN_STRING:
          step_tokens.push_back(make_token(stt_pkg::KIND_STRING, scan_start, held));
        SCAN_NUMBER:
          step_tokens.push_back(make_token(stt_pkg::KIND_NUMBER, scan_start, held));
        SCAN_TUPLE:
          step_tokens.push_back(make_token(stt_pkg::KIND_UNTERM_TUPLE, scan_start, held));
        default: ;
      endcase
      step_tokens.push_back(make_token(stt_pkg::KIND_END, scan_pos, '0));
      scan_mode  = SCAN_IDLE;
      scan_start = '0;
      scan_pos   = '0;
    end else begin
      case (scan_mode)
        SCAN_IDLE: begin
          if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
            // whitespace between tokens
          end else if (b == stt_pkg::ChrOpenTag) begin
            open_scan(SCAN_TAG);
          end else if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
            open_scan(SCAN_NAME);
          end else if (b == stt_pkg::ChrQuote) begin
            open_scan(SCAN_STRING);
          end else if (b >= "0" && b <= "9") begin
            open_scan(SCAN_NUMBER);
          end else if (b == stt_pkg::ChrOpenTup) begin
            open_scan(SCAN_TUPLE);
          end
          // anything else starts no token and is dropped
        end
        SCAN_TAG: begin
          if (b == stt_pkg::ChrCloseTag) begin
            step_tokens.push_back(make_token(stt_pkg::KIND_TAG, scan_start, held + 17'd1));
            scan_mode = SCAN_IDLE;
          end
        end
        SCAN_NAME: begin
          if (b == stt_pkg::ChrColon) begin
            step_tokens.push_back(make_token(stt_pkg::KIND_NAME, scan_start, held));
            scan_mode = SCAN_IDLE;
          end
        end
        SCAN_STRING: begin
          if (b == stt_pkg::ChrNewline) begin
            step_tokens.push_back(make_token(stt_pkg::KIND_STRING, scan_start, held));
            scan_mode = SCAN_IDLE;
          end
        end
        SCAN_NUMBER: begin
          if (b == stt_pkg::ChrNewline) begin
            step_tokens.push_back(make_token(stt_pkg::KIND_NUMBER, scan_start, held));
            scan_mode = SCAN_IDLE;
          end
        end
        SCAN_TUPLE: begin
          if (b == stt_pkg::ChrCloseTup) begin
            step_tokens.push_back(make_token(stt_pkg::KIND_TUPLE, scan_start, held + 17'd1));
            scan_mode = SCAN_IDLE;
          end
        end
        default: scan_mode = SCAN_IDLE;
      endcase
      if (scan_pos != 16'hFFFF) scan_pos++;
    end
    if (step_tokens.size() != 0) begin
      tail      = step_tokens.pop_back();
      tail.last = 1'b1;
      step_tokens.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predicts on every accepted input item, checks every token taken
  // --------------------------------------------------------------------------
  int     failures       = 0;
  int     tokens_checked = 0;
  int     in_stalls      = 0;
  int     typed_n        = -1;  // travels with the item being offered
  token_t typed_tok0     = '0;
  token_t typed_tok1     = '0;
  token_t want;

  function automatic void check_field(input string field, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && !in_if.ready) in_stalls++;
      if (in_if.valid && in_if.ready) begin
        tokenize_item(in_if.byte_value, in_if.end_of_buffer);
        if (typed_n >= 0) begin
          if (typed_n > 0) expected_tokens.push_back(typed_tok0);
          if (typed_n > 1) expected_tokens.push_back(typed_tok1);
        end else begin
          foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
        end
      end
      if (out_if.valid && out_if.ready) begin
        tokens_checked++;
        if (expected_tokens.size() == 0) begin
          failures++;
          $display("%0t: token with nothing expected: kind %0d start %0d len %0d last %0d",
                   $time, out_if.token_kind, out_if.start_position, out_if.token_length,
                   out_if.last_of_run);
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", int'(want.kind), int'(out_if.token_kind));
          check_field("start_position", int'(want.start), int'(out_if.start_position));
          check_field("token_length", int'(want.len), int'(out_if.token_length));
          check_field("last_of_run", int'(want.last), int'(out_if.last_of_run));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall per token, plus one long hold-off on request
  // --------------------------------------------------------------------------
  bit quiet       = 1'b0;  // no idling on either side while set
  int hold_cycles = 0;

  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int         items_sent   = 0;
  int         buffers_sent = 0;
  logic [7:0] buffer_bytes[$];

  task automatic send_item(input logic [7:0] b, input logic eob, input int fixed_n,
                           input token_t fix0, input token_t fix1);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.byte_value    <= b;
    in_if.end_of_buffer <= eob;
    typed_n             <= fixed_n;
    typed_tok0          <= fix0;
    typed_tok1          <= fix1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    if (eob) buffers_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eob);
    send_item(b, eob, -1, '0, '0);
  endtask

  // Any byte except the one that would close the open token.
  function automatic logic [7:0] body_byte(input logic [7:0] stop_byte);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == stop_byte) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    logic [7:0] b;
    b = 8'($urandom_range(8'h08, 8'h0D));
    if (b == 8'h08) b = 8'h20;
    return b;
  endfunction

  // Mostly well-formed token sequence with random bodies; some noise between
  // tokens, and the last token is sometimes left open for the end item.
  function automatic void compose_buffer();
    int         n_tok;
    int         body_len;
    logic [7:0] opener;
    logic [7:0] stop_byte;
    buffer_bytes.delete();
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      repeat ($urandom_range(0, 2)) buffer_bytes.push_back(blank_byte());
      if ($urandom_range(0, 9) == 0) buffer_bytes.push_back(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 4))
        0: begin
          opener    = stt_pkg::ChrOpenTag;
          stop_byte = stt_pkg::ChrCloseTag;
        end
        1: begin
          opener    = 8'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
          stop_byte = stt_pkg::ChrColon;
        end
        2: begin
          opener    = stt_pkg::ChrQuote;
          stop_byte = stt_pkg::ChrNewline;
        end
        3: begin
          opener    = 8'("0" + $urandom_range(0, 9));
          stop_byte = stt_pkg::ChrNewline;
        end
        default: begin
          opener    = stt_pkg::ChrOpenTup;
          stop_byte = stt_pkg::ChrCloseTup;
        end
      endcase
      buffer_bytes.push_back(opener);
      body_len = $urandom_range(0, 4);
      repeat (body_len) buffer_bytes.push_back(body_byte(stop_byte));
      if (t != n_tok - 1 || $urandom_range(0, 3) != 0) buffer_bytes.push_back(stop_byte);
    end
  endfunction

  // Directed rows. Positions restart at zero after each end item.
  row_t directed_rows [DirectedRows] = '{
    // one of each closed token, junk bytes, and an open number at the end
    '{stt_pkg::ChrOpenTag, 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{8'hFF, 1'b0, -1, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrCloseTag, 1'b0, 1, stt_pkg::KIND_TAG, 0, 3, stt_pkg::KIND_TAG, 0, 0},
    '{8'h20, 1'b0, -1, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{"N", 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrColon, 1'b0, 1, stt_pkg::KIND_NAME, 4, 1, stt_pkg::KIND_TAG, 0, 0},
    '{8'h00, 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrQuote, 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{"q", 1'b0, -1, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrNewline, 1'b0, 1, stt_pkg::KIND_STRING, 7, 2, stt_pkg::KIND_TAG, 0, 0},
    '{"9", 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrNewline, 1'b0, 1, stt_pkg::KIND_NUMBER, 10, 1, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrOpenTup, 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrCloseTup, 1'b0, 1, stt_pkg::KIND_TUPLE, 12, 2, stt_pkg::KIND_TAG, 0, 0},
    '{8'h80, 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{"0", 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{8'hFF, 1'b1, 2, stt_pkg::KIND_NUMBER, 15, 1, stt_pkg::KIND_END, 16, 0},
    // unterminated tag, name and tuple, an empty buffer, an open string
    '{stt_pkg::ChrOpenTag, 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrCloseTag, 1'b1, 2, stt_pkg::KIND_UNTERM_TAG, 0, 1, stt_pkg::KIND_END, 1, 0},
    '{"z", 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrColon, 1'b1, 2, stt_pkg::KIND_UNTERM_NAME, 0, 1, stt_pkg::KIND_END, 1, 0},
    '{stt_pkg::ChrOpenTup, 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{8'h00, 1'b1, 2, stt_pkg::KIND_UNTERM_TUPLE, 0, 1, stt_pkg::KIND_END, 1, 0},
    '{8'h7F, 1'b1, 1, stt_pkg::KIND_END, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrQuote, 1'b0, 0, stt_pkg::KIND_TAG, 0, 0, stt_pkg::KIND_TAG, 0, 0},
    '{stt_pkg::ChrNewline, 1'b1, 2, stt_pkg::KIND_STRING, 0, 1, stt_pkg::KIND_END, 1, 0}
  };

  initial begin
    token_t fix0;
    token_t fix1;
    int     random_items;

    in_if.valid         <= 1'b0;
    in_if.byte_value    <= '0;
    in_if.end_of_buffer <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    foreach (directed_rows[i]) begin
      fix0 = '{kind: directed_rows[i].k0, start: 16'(directed_rows[i].s0),
               len: 16'(directed_rows[i].l0), last: (directed_rows[i].fixed == 1)};
      fix1 = '{kind: directed_rows[i].k1, start: 16'(directed_rows[i].s1),
               len: 16'(directed_rows[i].l1), last: 1'b1};
      send_item(directed_rows[i].b, directed_rows[i].eob, directed_rows[i].fixed, fix0, fix1);
    end

    // Back-pressure: receiver holds off while a dense run of tags streams in,
    // so the record queue fills and the input side must stall.
    quiet       = 1'b1;
    hold_cycles = HoldCycles;
    repeat (24) begin
      send_byte(stt_pkg::ChrOpenTag, 1'b0);
      send_byte(stt_pkg::ChrCloseTag, 1'b0);
    end
    send_byte(8'h00, 1'b1);

    // Random buffers; one in four runs with no idling on either side.
    random_items = 0;
    while (random_items < RandomItems) begin
      compose_buffer();
      quiet = ($urandom_range(0, 3) == 0);
      foreach (buffer_bytes[i]) send_byte(buffer_bytes[i], 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      random_items += buffer_bytes.size() + 1;
    end
    in_if.valid <= 1'b0;
    quiet = 1'b0;

    // Drain, then give a stray extra token time to show up.
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d items in %0d buffers (directed tokens, a full-queue stall,",
             items_sent, buffers_sent);
    $display("random token streams); checked %0d tokens; input stalled %0d cycles.",
             tokens_checked, in_stalls);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/stt_pkg.sv
design/stt_if.sv
design/stt_scanner.sv
design/stt_queue.sv
design/stt_emitter.sv
design/scene_text_tokenizer.sv
test/tb_top.sv
